// ===== src/mmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmd_pkg - shared definitions for the memory map decoder
// Address map, store depths and command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmd_pkg;

  localparam int DATA_BYTES  = 65536;
  localparam int INSTR_BYTES = 65536;

  localparam int DATA_AW   = $clog2(DATA_BYTES);
  localparam int INSTR_AW  = $clog2(INSTR_BYTES);
  localparam int OFF_W     = (DATA_AW > INSTR_AW) ? DATA_AW : INSTR_AW;
  localparam int CLR_DEPTH = (DATA_BYTES > INSTR_BYTES) ? DATA_BYTES : INSTR_BYTES;

  // region offset widths: data region spans 2^26 bytes, instruction 2^24
  localparam int DREG_W = 26;
  localparam int IREG_W = 24;

  localparam logic [31:0] DATA_BASE   = 32'h2000_0000;
  localparam logic [31:0] DATA_LIMIT  = 32'h2400_0000;
  localparam logic [31:0] INSTR_BASE  = 32'h1000_0000;
  localparam logic [31:0] INSTR_LIMIT = 32'h1100_0000;
  localparam logic [31:0] IN_PORT_LO  = 32'h3000_0000;
  localparam logic [31:0] IN_PORT_HI  = 32'h3000_0003;
  localparam logic [31:0] OUT_PORT_LO = 32'h3000_0004;
  localparam logic [31:0] OUT_PORT_HI = 32'h3000_0007;
  localparam logic [31:0] EOF_WORD    = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_WORD_RD = 2'd0;
  localparam logic [1:0] CMD_WORD_WR = 2'd1;
  localparam logic [1:0] CMD_BYTE_RD = 2'd2;
  localparam logic [1:0] CMD_BYTE_WR = 2'd3;

endpackage

`default_nettype wire

// ===== src/memory_map_decoder_with_char_io.sv =====
// ----------------------------------------------------------------------------
// memory_map_decoder_with_char_io - memory map decoder with character I/O
// Decodes one access request into data store, instruction store, input port
// or output port; words are big-endian across byte addresses.
//
// Request channel: req_valid/req_stall carries command, address, write_data,
// privileged, host_char and host_eof. Response channel: rsp_valid/rsp_stall
// carries read_data, fault, out_valid, out_char and char_consumed, exactly
// one response per request.
// A byte sequencer walks the four bytes of a word through one shared
// address adder and a byte shifter, one byte per cycle on writes; on reads
// each byte passes an address state and a read state (registered RAM read).
// The response appears in the same cycle as the next request can be taken.
// After reset both stores are cleared by a pass over CLR_DEPTH addresses (65536
// here) during which req_stall stays high. A stalled response holds in its
// output register; the block may take one more request meanwhile and then
// waits with req_stall high until the response slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module memory_map_decoder_with_char_io
  import mmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  input  wire logic        privileged,
  input  wire logic [7:0]  host_char,
  input  wire logic        host_eof,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [31:0]      read_data,
  output logic             fault,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             char_consumed
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_RA    = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [DREG_W:0] DATA_LIM  = (DREG_W+1)'(DATA_BYTES);
  localparam logic [IREG_W:0] INSTR_LIM = (IREG_W+1)'(INSTR_BYTES);
  localparam logic [OFF_W:0]  DATA_CLR  = (OFF_W+1)'(DATA_BYTES);
  localparam logic [OFF_W:0]  INSTR_CLR = (OFF_W+1)'(INSTR_BYTES);
  localparam logic [OFF_W-1:0] CLR_LAST = OFF_W'(CLR_DEPTH - 1);

  logic [2:0]       state;
  logic [OFF_W-1:0] clr_cnt;
  logic [1:0]       k;
  logic [1:0]       last;
  logic             op_instr;
  logic [OFF_W-1:0] off;
  logic [31:0]      wshift;
  logic [31:0]      acc;
  logic             r_fault, r_ovalid, r_consumed;
  logic [7:0]       r_ochar;

  logic              req_acc, rsp_acc, slot_free;
  logic [31:0]       d_diff, i_diff;
  logic [DREG_W-1:0] d_off;
  logic [IREG_W-1:0] i_off;
  logic              d_in, i_in, d_ok1, d_ok4, i_ok1, i_ok4, in_port, out_port;
  logic [OFF_W-1:0]  acc_addr;
  logic [7:0]        d_rbyte, i_rbyte;
  logic              d_we, i_we;
  logic [OFF_W-1:0]  mem_waddr;
  logic [7:0]        mem_wbyte;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_acc   = rsp_valid && !rsp_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  // address decode
  assign d_diff   = address - DATA_BASE;
  assign i_diff   = address - INSTR_BASE;
  assign d_off    = d_diff[DREG_W-1:0];
  assign i_off    = i_diff[IREG_W-1:0];
  assign d_in     = (address >= DATA_BASE) && (address < DATA_LIMIT);
  assign i_in     = (address >= INSTR_BASE) && (address < INSTR_LIMIT);
  assign d_ok1    = d_in && ({1'b0, d_off} < DATA_LIM);
  assign d_ok4    = d_in && (({1'b0, d_off} + (DREG_W+1)'(4)) <= DATA_LIM);
  assign i_ok1    = i_in && ({1'b0, i_off} < INSTR_LIM);
  assign i_ok4    = i_in && (({1'b0, i_off} + (IREG_W+1)'(4)) <= INSTR_LIM);
  assign in_port  = (address >= IN_PORT_LO) && (address <= IN_PORT_HI);
  assign out_port = (address >= OUT_PORT_LO) && (address <= OUT_PORT_HI);

  // shared byte address adder
  assign acc_addr = off + OFF_W'(k);

  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : acc_addr;
  assign mem_wbyte = (state == S_CLEAR) ? 8'h00 : wshift[31:24];
  assign d_we = ((state == S_CLEAR) && ({1'b0, clr_cnt} < DATA_CLR)) ||
                ((state == S_WR) && !op_instr);
  assign i_we = ((state == S_CLEAR) && ({1'b0, clr_cnt} < INSTR_CLR)) ||
                ((state == S_WR) && op_instr);

  mmd_ram #(.DEPTH(DATA_BYTES)) u_data (
    .clk   (clk),
    .we    (d_we),
    .waddr (mem_waddr[DATA_AW-1:0]),
    .wdata (mem_wbyte),
    .raddr (acc_addr[DATA_AW-1:0]),
    .rdata (d_rbyte)
  );

  mmd_ram #(.DEPTH(INSTR_BYTES)) u_instr (
    .clk   (clk),
    .we    (i_we),
    .waddr (mem_waddr[INSTR_AW-1:0]),
    .wdata (mem_wbyte),
    .raddr (acc_addr[INSTR_AW-1:0]),
    .rdata (i_rbyte)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + OFF_W'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            state <= S_FIN;
            unique case (command)
              CMD_WORD_RD: begin
                if ((!privileged && d_ok4) || (privileged && i_ok4)) begin
                  state <= S_RA;
                end
              end
              CMD_WORD_WR: begin
                if ((!privileged && d_ok4) || (!out_port && privileged && i_ok4)) begin
                  state <= S_WR;
                end
              end
              CMD_BYTE_RD: begin
                if (d_ok1 || i_ok1) begin
                  state <= S_RA;
                end
              end
              CMD_BYTE_WR: begin
                if (d_ok1) begin
                  state <= S_WR;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_WR: begin
          if (k == last) begin
            state <= S_FIN;
          end
        end
        S_RA: state <= S_RD;
        S_RD: state <= (k == last) ? S_FIN : S_RA;
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        k          <= 2'd0;
        acc        <= 32'h0;
        r_fault    <= 1'b0;
        r_ovalid   <= 1'b0;
        r_ochar    <= 8'h00;
        r_consumed <= 1'b0;
        wshift     <= (command == CMD_BYTE_WR) ? {write_data[7:0], 24'h0} : write_data;
        last       <= (command == CMD_WORD_RD || command == CMD_WORD_WR) ? 2'd3 : 2'd0;
        op_instr   <= 1'b0;
        off        <= OFF_W'(d_off);
        unique case (command)
          CMD_WORD_RD: begin
            if (!privileged && d_ok4) begin
              op_instr <= 1'b0;
            end else if (!privileged && in_port) begin
              acc        <= host_eof ? EOF_WORD : {24'h0, host_char};
              r_consumed <= !host_eof;
            end else if (privileged && i_ok4) begin
              op_instr <= 1'b1;
              off      <= OFF_W'(i_off);
            end else begin
              r_fault <= 1'b1;
            end
          end
          CMD_WORD_WR: begin
            if (!privileged && d_ok4) begin
              op_instr <= 1'b0;
            end else if (out_port) begin
              r_ovalid <= 1'b1;
              r_ochar  <= (address == OUT_PORT_LO) ? write_data[7:0] : 8'h00;
            end else if (privileged && i_ok4) begin
              op_instr <= 1'b1;
              off      <= OFF_W'(i_off);
            end else begin
              r_fault <= 1'b1;
            end
          end
          CMD_BYTE_RD: begin
            if (d_ok1) begin
              op_instr <= 1'b0;
            end else if (i_ok1) begin
              op_instr <= 1'b1;
              off      <= OFF_W'(i_off);
            end else begin
              r_fault <= 1'b1;
            end
          end
          CMD_BYTE_WR: begin
            if (d_ok1) begin
              op_instr <= 1'b0;
            end else if (out_port) begin
              r_ovalid <= 1'b1;
              r_ochar  <= (address == OUT_PORT_LO) ? write_data[7:0] : 8'h00;
            end else begin
              r_fault <= 1'b1;
            end
          end
          default: r_fault <= 1'b1;
        endcase
      end
      S_WR: begin
        wshift <= {wshift[23:0], 8'h00};
        k      <= k + 2'd1;
      end
      S_RD: begin
        acc <= {acc[23:0], op_instr ? i_rbyte : d_rbyte};
        k   <= k + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_acc) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && slot_free) begin
      read_data     <= acc;
      fault         <= r_fault;
      out_valid     <= r_ovalid;
      out_char      <= r_ochar;
      char_consumed <= r_consumed;
    end
  end

endmodule

`default_nettype wire

// ===== src/mmd_ram.sv =====
// ----------------------------------------------------------------------------
// mmd_ram - byte-wide simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmd_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/mmd_checker.sv =====
// ----------------------------------------------------------------------------
// mmd_checker - port-level checks for the memory map decoder
// Response consistency and reset behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_stall,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [31:0] read_data,
  input wire logic        fault,
  input wire logic        out_valid,
  input wire logic [7:0]  out_char,
  input wire logic        char_consumed
);

  // stores clear right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken during clear pass");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fault |-> (read_data == 32'h0) && !out_valid && !char_consumed)
    else $error("fault response carries side effects");

  a_char_only_on_emit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> (out_char == 8'h00))
    else $error("character without emit");

  a_consume_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && char_consumed |-> (read_data[31:8] == 24'h0) && !out_valid)
    else $error("consumed character response malformed");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(fault) &&
    $stable(out_valid) && $stable(out_char) && $stable(char_consumed))
    else $error("stalled response changed");

endmodule

bind memory_map_decoder_with_char_io mmd_checker u_mmd_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - memory_map_decoder_with_char_io self-checking bench
// Drives access requests through the valid/stall request channel and checks
// every response against a behavioral model of the address map. The model
// covers the big-endian data and instruction stores, the character ports and
// the fault rules. Stimulus is a short directed set followed by random
// requests in phases with idle gaps, response stalls and one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mmd_pkg::*;

typedef struct packed {
  logic [31:0] read_data;
  logic        fault;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        char_consumed;
} access_reply_t;

class mem_map_scoreboard;
  logic [7:0]    data_mem  [DATA_BYTES];
  logic [7:0]    instr_mem [INSTR_BYTES];
  access_reply_t expected_replies[$];
  int            errors;

  function new();
    foreach (data_mem[i]) data_mem[i] = 8'h00;
    foreach (instr_mem[i]) instr_mem[i] = 8'h00;
    errors = 0;
  endfunction

  function bit in_built(logic [31:0] a, logic [31:0] base, logic [31:0] limit,
                        longint depth, longint len, output longint off);
    off = 0;
    if (a < base || a >= limit) return 0;
    off = {32'd0, a - base};
    if (off + len > depth) return 0;
    return 1;
  endfunction

  function logic [31:0] word_at(bit instr, longint off);
    if (instr)
      return {instr_mem[off], instr_mem[off+1], instr_mem[off+2], instr_mem[off+3]};
    return {data_mem[off], data_mem[off+1], data_mem[off+2], data_mem[off+3]};
  endfunction

  function void store_word(bit instr, longint off, logic [31:0] v);
    for (int i = 0; i < 4; i++) begin
      if (instr) instr_mem[off+i] = v[31-8*i -: 8];
      else data_mem[off+i] = v[31-8*i -: 8];
    end
  endfunction

  // Note an accepted request and queue the response it must produce.
  function void note_access(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wd,
                            logic priv, logic [7:0] hc, logic heof);
    access_reply_t r;
    longint        off;
    bit            in_port, out_port;
    r = '0;
    in_port  = (addr >= IN_PORT_LO) && (addr <= IN_PORT_HI);
    out_port = (addr >= OUT_PORT_LO) && (addr <= OUT_PORT_HI);
    case (cmd)
      CMD_WORD_RD: begin
        if (!priv && in_built(addr, DATA_BASE, DATA_LIMIT, DATA_BYTES, 4, off)) begin
          r.read_data = word_at(0, off);
        end else if (!priv && in_port) begin
          if (heof) begin
            r.read_data = EOF_WORD;
          end else begin
            r.read_data = {24'd0, hc};
            r.char_consumed = 1'b1;
          end
        end else if (priv && in_built(addr, INSTR_BASE, INSTR_LIMIT, INSTR_BYTES, 4,
                                      off)) begin
          r.read_data = word_at(1, off);
        end else begin
          r.fault = 1'b1;
        end
      end
      CMD_WORD_WR: begin
        if (!priv && in_built(addr, DATA_BASE, DATA_LIMIT, DATA_BYTES, 4, off)) begin
          store_word(0, off, wd);
        end else if (out_port) begin
          r.out_valid = 1'b1;
          r.out_char  = (addr == OUT_PORT_LO) ? wd[7:0] : 8'h00;
        end else if (priv && in_built(addr, INSTR_BASE, INSTR_LIMIT, INSTR_BYTES, 4,
                                      off)) begin
          store_word(1, off, wd);
        end else begin
          r.fault = 1'b1;
        end
      end
      CMD_BYTE_RD: begin
        if (in_built(addr, DATA_BASE, DATA_LIMIT, DATA_BYTES, 1, off)) begin
          r.read_data = {24'd0, data_mem[off]};
        end else if (in_built(addr, INSTR_BASE, INSTR_LIMIT, INSTR_BYTES, 1, off)) begin
          r.read_data = {24'd0, instr_mem[off]};
        end else begin
          r.fault = 1'b1;
        end
      end
      default: begin
        if (in_built(addr, DATA_BASE, DATA_LIMIT, DATA_BYTES, 1, off)) begin
          data_mem[off] = wd[7:0];
        end else if (out_port) begin
          r.out_valid = 1'b1;
          r.out_char  = (addr == OUT_PORT_LO) ? wd[7:0] : 8'h00;
        end else begin
          r.fault = 1'b1;
        end
      end
    endcase
    expected_replies.push_back(r);
  endfunction

  function void check_reply(logic [31:0] rd, logic f, logic ov, logic [7:0] oc,
                            logic cc);
    access_reply_t e;
    if (expected_replies.size() == 0) begin
      $error("unexpected response: read_data %h fault %b", rd, f);
      errors++;
      return;
    end
    e = expected_replies.pop_front();
    if (rd !== e.read_data) begin
      $error("read_data: expected %h, got %h", e.read_data, rd);
      errors++;
    end
    if (f !== e.fault) begin
      $error("fault: expected %b, got %b", e.fault, f);
      errors++;
    end
    if (ov !== e.out_valid) begin
      $error("out_valid: expected %b, got %b", e.out_valid, ov);
      errors++;
    end
    if (oc !== e.out_char) begin
      $error("out_char: expected %h, got %h", e.out_char, oc);
      errors++;
    end
    if (cc !== e.char_consumed) begin
      $error("char_consumed: expected %b, got %b", e.char_consumed, cc);
      errors++;
    end
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  command;
  logic [31:0] address;
  logic [31:0] write_data;
  logic        privileged;
  logic [7:0]  host_char;
  logic        host_eof;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [31:0] read_data;
  logic        fault;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        char_consumed;

  mem_map_scoreboard sb = new();

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  bit hold_request  = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  memory_map_decoder_with_char_io DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .command(command), .address(address), .write_data(write_data),
    .privileged(privileged), .host_char(host_char), .host_eof(host_eof),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .read_data(read_data), .fault(fault), .out_valid(out_valid),
    .out_char(out_char), .char_consumed(char_consumed)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // response side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left--;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      rsp_stall = 1'b1;
    end else begin
      rsp_stall = ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_reply(read_data, fault, out_valid, out_char, char_consumed);
  end

  task automatic issue_request(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wd,
                               logic priv, logic [7:0] hc, logic heof);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid  = 1'b1;
    command    = cmd;
    address    = addr;
    write_data = wd;
    privileged = priv;
    host_char  = hc;
    host_eof   = heof;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_access(cmd, addr, wd, priv, hc, heof);
    @(negedge clk);
  endtask

  function automatic logic [31:0] region_offset(int unsigned depth, int reg_w);
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(0, 63);
    if (k < 85) return depth - 1 - $urandom_range(0, 7);
    if (k < 95) return $urandom_range(0, depth - 1);
    return depth + $urandom_range(0, (1 << reg_w) - depth - 1);
  endfunction

  task automatic random_request();
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic        priv;
    int          k;
    bit          word_cmd;
    cmd      = 2'($urandom_range(0, 3));
    word_cmd = (cmd == CMD_WORD_RD) || (cmd == CMD_WORD_WR);
    priv     = 1'($urandom_range(0, 1));
    k        = $urandom_range(0, 99);
    if (k < 35) begin
      addr = DATA_BASE + region_offset(DATA_BYTES, DREG_W);
      if (word_cmd) priv = ($urandom_range(0, 99) >= 85);
    end else if (k < 60) begin
      addr = INSTR_BASE + region_offset(INSTR_BYTES, IREG_W);
      if (word_cmd) priv = ($urandom_range(0, 99) < 85);
    end else if (k < 75) begin
      addr = IN_PORT_LO + $urandom_range(0, 7);
    end else if (k < 85) begin
      case ($urandom_range(0, 9))
        0: addr = DATA_BASE - 1;
        1: addr = DATA_LIMIT - 1;
        2: addr = DATA_LIMIT;
        3: addr = INSTR_BASE - 1;
        4: addr = INSTR_LIMIT - 1;
        5: addr = INSTR_LIMIT;
        6: addr = IN_PORT_LO - 1;
        7: addr = OUT_PORT_HI + 1;
        8: addr = 32'h0000_0000;
        default: addr = 32'hFFFF_FFFF;
      endcase
    end else begin
      addr = $urandom;
    end
    issue_request(cmd, addr, $urandom, priv, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 99) < 20);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (n) random_request();
  endtask

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    rsp_stall  = 1'b0;
    command    = CMD_WORD_RD;
    address    = '0;
    write_data = '0;
    privileged = 1'b0;
    host_char  = '0;
    host_eof   = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: store edges, big-endian order, ports, faults
    issue_request(CMD_WORD_RD, DATA_BASE, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_WR, DATA_BASE, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_WR, DATA_BASE + 1, 32'h1234_5678, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_RD, DATA_BASE, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_RD, DATA_BASE + 4, 32'h0, 1'b1, 8'h00, 1'b0);
    issue_request(CMD_WORD_WR, DATA_BASE + DATA_BYTES - 4, 32'hA5C3_0F81, 1'b0,
                  8'h00, 1'b0);
    issue_request(CMD_WORD_RD, DATA_BASE + DATA_BYTES - 3, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_WR, DATA_BASE + DATA_BYTES - 1, 32'hFFFF_FF7E, 1'b1,
                  8'h00, 1'b0);
    issue_request(CMD_BYTE_RD, DATA_BASE + DATA_BYTES - 1, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_RD, DATA_BASE + DATA_BYTES, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_WR, INSTR_BASE, 32'hDEAD_BEEF, 1'b1, 8'h00, 1'b0);
    issue_request(CMD_WORD_RD, INSTR_BASE, 32'h0, 1'b1, 8'h00, 1'b0);
    issue_request(CMD_WORD_RD, INSTR_BASE, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_RD, INSTR_BASE + 3, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_WR, INSTR_BASE, 32'h55, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_RD, IN_PORT_LO, 32'h0, 1'b0, 8'hFF, 1'b0);
    issue_request(CMD_WORD_RD, IN_PORT_HI, 32'h0, 1'b0, 8'h41, 1'b1);
    issue_request(CMD_WORD_RD, IN_PORT_LO + 1, 32'h0, 1'b1, 8'h42, 1'b0);
    issue_request(CMD_BYTE_RD, IN_PORT_LO, 32'h0, 1'b0, 8'h43, 1'b0);
    issue_request(CMD_WORD_WR, OUT_PORT_LO, 32'hFFFF_FFC3, 1'b1, 8'h00, 1'b0);
    issue_request(CMD_BYTE_WR, OUT_PORT_HI, 32'h7E, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_RD, OUT_PORT_LO, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_WR, IN_PORT_LO, 32'h1, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_WORD_RD, 32'h0000_0000, 32'h0, 1'b0, 8'h00, 1'b0);
    issue_request(CMD_BYTE_WR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);

    random_phase(250, 0, 0);
    hold_request = 1'b1;
    random_phase(200, 0, 0);
    random_phase(220, 51, 0);
    random_phase(220, 0, 51);
    random_phase(220, 22, 22);
    random_phase(190, 0, 0);
    req_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== memory_map_decoder_with_char_io.f =====
src/mmd_pkg.sv
src/mmd_ram.sv
src/memory_map_decoder_with_char_io.sv
src/mmd_checker.sv
sim/testbench.sv
